// ----- rtl/core/tmrq_pkg.sv -----
// ----------------------------------------------------------------------------
// tmrq_pkg
// Types and constants shared by the timestamp matched ring queue.
// ----------------------------------------------------------------------------
package tmrq_pkg;

	localparam int DEPTH      = 16;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int LVL_W      = $clog2(DEPTH + 1);
	localparam int STAMP_W    = 48;
	localparam int SIZE_W     = 14;
	localparam int KIND_W     = 8;
	localparam int WINDOW_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [SIZE_W-1:0]   MIN_SIZE_EXCL  = 14'd16;
	localparam logic [KIND_W-1:0]   KIND_REQUIRED  = 8'd5;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 16'd20;
	localparam logic [SIZE_W-1:0]   MAX_SIZE_RESET = 14'd8196;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRY_SIZE = 1'd1;

	typedef struct packed {
		logic              op;
		logic [STAMP_W-1:0] stamp;
		logic [SIZE_W-1:0]  payload_size;
		logic [KIND_W-1:0]  payload_kind_byte;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic              found;
		logic [PTR_W-1:0]  slot;
		logic [SIZE_W-1:0] entry_size;
		logic [LVL_W-1:0]  queue_level;
	} out_item_t;

	typedef struct packed {
		logic [WINDOW_W-1:0] match_window;
		logic [SIZE_W-1:0]   max_entry_size;
	} cfg_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [SIZE_W-1:0]  size;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

endpackage

// ----- rtl/core/tmrq_mem.sv -----
// ----------------------------------------------------------------------------
// tmrq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmrq_mem (
	input  logic              clk,
	input  tmrq_pkg::mem_req_t req,
	output tmrq_pkg::entry_t   rdata
);

	tmrq_pkg::entry_t mem_q [tmrq_pkg::DEPTH];
	tmrq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/tmrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmrq_ctrl
// Pointers, level and the lookup scan sequencer around the entry store.
// ----------------------------------------------------------------------------
module tmrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  tmrq_pkg::cfg_t      cfg,
	input  logic                start,
	input  tmrq_pkg::in_item_t  item,
	output logic                busy,
	output logic                done,
	output tmrq_pkg::out_item_t result,
	output tmrq_pkg::mem_req_t  mem_req,
	input  tmrq_pkg::entry_t    mem_rdata
);

	typedef enum logic {
		IDLE,
		SCAN
	} state_t;

	state_t                        state_q;
	logic [tmrq_pkg::PTR_W-1:0]    wptr_q;
	logic [tmrq_pkg::PTR_W-1:0]    rptr_q;
	logic [tmrq_pkg::PTR_W-1:0]    iss_q;
	logic [tmrq_pkg::LVL_W-1:0]    count_q;
	logic                          valid_s1;
	logic [tmrq_pkg::STAMP_W-1:0]  lo_q;
	logic [tmrq_pkg::STAMP_W:0]    hi_q;
	logic                          done_q;
	tmrq_pkg::out_item_t           result_q;

	logic                          take;
	logic                          add_ok;
	logic                          full;
	logic [tmrq_pkg::STAMP_W-1:0]  win_ext;
	logic [tmrq_pkg::STAMP_W-1:0]  lo_calc;
	logic [tmrq_pkg::STAMP_W:0]    hi_calc;
	logic                          below_lo;
	logic                          within_hi;
	logic                          idle_done;
	logic                          scan_pop;
	logic                          scan_end;
	tmrq_pkg::out_item_t           res_d;

	assign busy = (state_q != IDLE);
	assign take = start && !busy;
	assign full = (count_q == tmrq_pkg::LVL_W'(tmrq_pkg::DEPTH));

	assign add_ok = (item.op == tmrq_pkg::OP_ADD)
		&& (item.payload_size > tmrq_pkg::MIN_SIZE_EXCL)
		&& (item.payload_size <= cfg.max_entry_size)
		&& (item.payload_kind_byte == tmrq_pkg::KIND_REQUIRED);

	assign win_ext  = tmrq_pkg::STAMP_W'(cfg.match_window);
	assign lo_calc  = (item.stamp < win_ext) ? '0 : item.stamp - win_ext;
	// upper bound keeps the carry so it never wraps
	assign hi_calc  = {1'b0, item.stamp} + {1'b0, win_ext};

	assign below_lo  = (mem_rdata.stamp < lo_q);
	assign within_hi = ({1'b0, mem_rdata.stamp} <= hi_q);

	assign idle_done = take && ((item.op == tmrq_pkg::OP_ADD) || (count_q == '0));
	// entry under test is always the oldest one held
	assign scan_pop  = (state_q == SCAN) && valid_s1 && (below_lo || within_hi);
	assign scan_end  = (state_q == SCAN) && valid_s1
		&& (!below_lo || (count_q == tmrq_pkg::LVL_W'(1)));

	always_comb begin
		mem_req.we          = take && add_ok;
		mem_req.waddr       = wptr_q;
		mem_req.wdata.stamp = item.stamp;
		mem_req.wdata.size  = item.payload_size;
		// reads run one entry ahead; overshoot data is never used
		mem_req.re          = (state_q == SCAN);
		mem_req.raddr       = iss_q;
	end

	always_comb begin
		res_d = result_q;
		if (take) begin
			res_d = '0;
			if (item.op == tmrq_pkg::OP_ADD) begin
				res_d.accepted    = add_ok;
				res_d.slot        = add_ok ? wptr_q : '0;
				res_d.queue_level = (add_ok && !full) ? count_q + 1'b1 : count_q;
			end
		end else if (scan_end) begin
			if (below_lo) begin
				res_d.queue_level = '0;
			end else if (within_hi) begin
				res_d.found       = 1'b1;
				res_d.slot        = rptr_q;
				res_d.entry_size  = mem_rdata.size;
				res_d.queue_level = count_q - 1'b1;
			end else begin
				res_d.queue_level = count_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			wptr_q   <= '0;
			rptr_q   <= '0;
			iss_q    <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
		end else begin
			done_q   <= idle_done || scan_end;
			result_q <= res_d;
			unique case (state_q)
				IDLE: begin
					if (take) begin
						if (item.op == tmrq_pkg::OP_ADD) begin
							if (add_ok) begin
								wptr_q <= tmrq_pkg::ptr_next(wptr_q);
								if (full) begin
									rptr_q <= tmrq_pkg::ptr_next(rptr_q);
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
						end else if (count_q != '0) begin
							state_q  <= SCAN;
							iss_q    <= rptr_q;
							valid_s1 <= 1'b0;
							lo_q     <= lo_calc;
							hi_q     <= hi_calc;
						end
					end
				end
				SCAN: begin
					iss_q    <= tmrq_pkg::ptr_next(iss_q);
					valid_s1 <= 1'b1;
					if (scan_pop) begin
						rptr_q  <= tmrq_pkg::ptr_next(rptr_q);
						count_q <= count_q - 1'b1;
					end
					if (scan_end) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/timestamp_matched_ring_queue_unit.sv -----
// ----------------------------------------------------------------------------
// timestamp_matched_ring_queue_unit
// Ring queue of timestamped entries with windowed lookup against a frame time.
// ----------------------------------------------------------------------------
// Add, or lookup on an empty queue: the result is registered in the cycle after start is taken.
// Lookup: the scan reads the entry store one entry per cycle, examining 1 to
// DEPTH entries from the oldest; the result is registered when the scan ends.
// busy is high during a scan, and start is not taken while busy; an add never
// raises busy. done pulses for one cycle, no stall possible.
// Reset (arst_n low, async): queue empty, pointers zero, registers to defaults.
module timestamp_matched_ring_queue_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  tmrq_pkg::in_item_t                item,
	output logic                              busy,
	output logic                              done,
	output tmrq_pkg::out_item_t               result,
	input  logic                              cfg_we,
	input  logic [tmrq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmrq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tmrq_pkg::cfg_t     cfg_q;
	tmrq_pkg::mem_req_t mem_req;
	tmrq_pkg::entry_t   mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_window   <= tmrq_pkg::WINDOW_RESET;
			cfg_q.max_entry_size <= tmrq_pkg::MAX_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmrq_pkg::CFG_MATCH_WINDOW: begin
					cfg_q.match_window <= cfg_data;
				end
				tmrq_pkg::CFG_MAX_ENTRY_SIZE: begin
					cfg_q.max_entry_size <= cfg_data[tmrq_pkg::SIZE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tmrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	tmrq_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule
